// File: rtl/ptls_pkg.sv
// ----------------------------------------------------------------------------
// ptls_pkg
// Shared types, character codes and helpers for the path text to line
// segments core.
// ----------------------------------------------------------------------------
`default_nettype none

package ptls_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OUT_COORD_W    = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_MOVE  = 8'h4D;  // 'M'
  localparam logic [7:0] CH_LINE  = 8'h4C;  // 'L'
  localparam logic [7:0] CH_CUBIC = 8'h43;  // 'C'
  localparam logic [7:0] CH_CLOSE = 8'h7A;  // 'z'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [2:0] OPS_PAIR  = 3'd2;
  localparam logic [2:0] OPS_CUBIC = 3'd6;

  typedef enum logic [1:0] {
    PH_COMMAND = 2'b01,
    PH_OPERAND = 2'b10
  } phase_t;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CUBIC = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SEGMENT = 3'd0,
    ST_END     = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_DIGIT   = 3'd3,
    ST_DECIMAL = 3'd4,
    ST_EARLY   = 3'd5,
    ST_CUBIC   = 3'd6
  } status_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] x_from;
    logic [OUT_COORD_W-1:0] y_from;
    logic [OUT_COORD_W-1:0] x_to;
    logic [OUT_COORD_W-1:0] y_to;
    status_t                status;
    logic                   path_done;
  } result_t;

  function automatic result_t status_res(input status_t s);
    result_t r;
    r        = '0;
    r.status = s;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ptls_parser.sv
// ----------------------------------------------------------------------------
// ptls_parser
// Path text parser state and combinational step logic; yields up to two
// results for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ptls_parser import ptls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] path_char,
  input  wire logic       final_char,
  output logic [1:0]      res_count,
  output result_t         res0,
  output result_t         res1
);

  localparam int PW = COORD_BITS + 4;

  phase_t                phase, phase_next;
  cmd_t                  kind, kind_next;
  logic [2:0]            opcnt, opcnt_next;
  logic [COORD_BITS-1:0] accum, accum_next;
  logic                  in_num, in_num_next;
  logic [COORD_BITS-1:0] held_x, held_x_next;
  logic [COORD_BITS-1:0] cur_x, cur_x_next;
  logic [COORD_BITS-1:0] cur_y, cur_y_next;
  logic [COORD_BITS-1:0] start_x, start_x_next;
  logic [COORD_BITS-1:0] start_y, start_y_next;
  logic                  err, err_next;

  logic                  is_digit, is_ws, is_dot;
  logic [PW-1:0]         prod;
  logic [COORD_BITS-1:0] sat;
  logic                  byte_fin, take_cmd;
  logic [2:0]            cnt1, need;
  logic [COORD_BITS-1:0] fin_val;
  result_t               fres, cres, eres;
  logic                  fe, ce, ee;

  function automatic result_t seg_res(input logic [COORD_BITS-1:0] xf,
                                      input logic [COORD_BITS-1:0] yf,
                                      input logic [COORD_BITS-1:0] xt,
                                      input logic [COORD_BITS-1:0] yt);
    result_t r;
    r.x_from    = OUT_COORD_W'(xf);
    r.y_from    = OUT_COORD_W'(yf);
    r.x_to      = OUT_COORD_W'(xt);
    r.y_to      = OUT_COORD_W'(yt);
    r.status    = ST_SEGMENT;
    r.path_done = 1'b0;
    return r;
  endfunction

  assign is_digit = (path_char >= CH_ZERO) && (path_char <= CH_NINE);
  assign is_ws    = (path_char == CH_SPACE) || ((path_char >= CH_TAB) && (path_char <= CH_CR));
  assign is_dot   = (path_char == CH_DOT);
  assign prod     = ({{4{1'b0}}, accum} << 3) + ({{4{1'b0}}, accum} << 1)
                    + PW'(path_char[3:0]);
  assign sat      = (|prod[PW-1:COORD_BITS]) ? {COORD_BITS{1'b1}} : prod[COORD_BITS-1:0];

  always_comb begin
    phase_next   = phase;
    kind_next    = kind;
    opcnt_next   = opcnt;
    accum_next   = accum;
    in_num_next  = in_num;
    held_x_next  = held_x;
    cur_x_next   = cur_x;
    cur_y_next   = cur_y;
    start_x_next = start_x;
    start_y_next = start_y;
    err_next     = err;
    byte_fin     = 1'b0;
    take_cmd     = 1'b0;
    cnt1         = '0;
    need         = OPS_PAIR;
    fin_val      = '0;
    fres         = '0;
    cres         = '0;
    eres         = '0;
    fe           = 1'b0;
    ce           = 1'b0;
    ee           = 1'b0;

    if (!err) begin
      // byte stage
      if (in_num) begin
        if (is_digit) begin
          accum_next = sat;
        end else if (is_dot) begin
          cres     = status_res(ST_DECIMAL);
          ce       = 1'b1;
          err_next = 1'b1;
        end else begin
          byte_fin = 1'b1;
        end
      end else if (phase == PH_OPERAND) begin
        if (is_digit) begin
          in_num_next = 1'b1;
          accum_next  = COORD_BITS'(path_char[3:0]);
        end else if (!is_ws) begin
          cres     = status_res(ST_DIGIT);
          ce       = 1'b1;
          err_next = 1'b1;
        end
      end else if (!is_ws) begin
        take_cmd = 1'b1;
      end

      // operand completion
      if (!err_next && in_num_next && (byte_fin || final_char)) begin
        fin_val     = accum_next;
        in_num_next = 1'b0;
        accum_next  = '0;
        cnt1        = opcnt + 3'd1;
        need        = (kind == CMD_CUBIC) ? OPS_CUBIC : OPS_PAIR;
        opcnt_next  = cnt1;
        if (cnt1[0]) begin
          held_x_next = fin_val;
        end
        if (cnt1 >= need) begin
          phase_next = PH_COMMAND;
          opcnt_next = '0;
          case (kind)
            CMD_MOVE: begin
              start_x_next = held_x_next;
              start_y_next = fin_val;
              cur_x_next   = held_x_next;
              cur_y_next   = fin_val;
            end
            CMD_LINE: begin
              fres       = seg_res(cur_x, cur_y, held_x_next, fin_val);
              fe         = 1'b1;
              cur_x_next = held_x_next;
              cur_y_next = fin_val;
            end
            default: begin
              fres     = status_res(ST_CUBIC);
              fe       = 1'b1;
              err_next = 1'b1;
            end
          endcase
        end
      end

      // byte after a finished number
      if (byte_fin && !err_next && !is_ws) begin
        if (phase_next == PH_COMMAND) begin
          take_cmd = 1'b1;
        end else begin
          cres     = status_res(ST_DIGIT);
          ce       = 1'b1;
          err_next = 1'b1;
        end
      end

      // command letter
      if (take_cmd) begin
        if (path_char == CH_MOVE || path_char == CH_LINE || path_char == CH_CUBIC) begin
          case (path_char)
            CH_MOVE: kind_next = CMD_MOVE;
            CH_LINE: kind_next = CMD_LINE;
            default: kind_next = CMD_CUBIC;
          endcase
          phase_next  = PH_OPERAND;
          opcnt_next  = '0;
          in_num_next = 1'b0;
          accum_next  = '0;
        end else if (path_char == CH_CLOSE) begin
          cres       = seg_res(cur_x_next, cur_y_next, start_x_next, start_y_next);
          ce         = 1'b1;
          cur_x_next = start_x_next;
          cur_y_next = start_y_next;
        end else begin
          cres     = status_res(ST_UNKNOWN);
          ce       = 1'b1;
          err_next = 1'b1;
        end
      end

      // end of text
      if (final_char && !err_next) begin
        if (phase_next != PH_COMMAND) begin
          eres     = status_res(ST_EARLY);
          ee       = 1'b1;
          err_next = 1'b1;
        end else if (!fe && !ce) begin
          eres = status_res(ST_END);
          ee   = 1'b1;
        end
      end
    end

    if (final_char) begin
      phase_next   = PH_COMMAND;
      kind_next    = CMD_MOVE;
      opcnt_next   = '0;
      accum_next   = '0;
      in_num_next  = 1'b0;
      held_x_next  = '0;
      cur_x_next   = '0;
      cur_y_next   = '0;
      start_x_next = '0;
      start_y_next = '0;
      err_next     = 1'b0;
    end
  end

  always_comb begin
    res_count = {1'b0, fe} + {1'b0, ce} + {1'b0, ee};
    res0      = fe ? fres : (ce ? cres : eres);
    res1      = (fe && ce) ? cres : eres;
    if (res_count == 2'd1) begin
      res0.path_done = final_char;
    end
    if (res_count == 2'd2) begin
      res1.path_done = final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_COMMAND;
      kind    <= CMD_MOVE;
      opcnt   <= '0;
      accum   <= '0;
      in_num  <= 1'b0;
      held_x  <= '0;
      cur_x   <= '0;
      cur_y   <= '0;
      start_x <= '0;
      start_y <= '0;
      err     <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      kind    <= kind_next;
      opcnt   <= opcnt_next;
      accum   <= accum_next;
      in_num  <= in_num_next;
      held_x  <= held_x_next;
      cur_x   <= cur_x_next;
      cur_y   <= cur_y_next;
      start_x <= start_x_next;
      start_y <= start_y_next;
      err     <= err_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/path_text_to_line_segments_core.sv
// ----------------------------------------------------------------------------
// path_text_to_line_segments_core
// Parses path text one byte per request into line segments and status
// results, buffered in a small result queue.
// ----------------------------------------------------------------------------
// ordering: the results of an accepted byte are registered in the result
//   queue and offered in order; a second result follows the first
// throughput: one byte per cycle; the four-entry result queue drops tready
//   while it holds more than two results
// reset: synchronous rst returns the parser to its idle state and empties
//   the queue
`default_nettype none

module path_text_to_line_segments_core import ptls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // path_char[7:0]
  input  wire logic        s_tlast,   // final_char
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // x_from, y_from, x_to, y_to
  output logic [2:0]       m_tuser,   // status
  output logic             m_tlast    // path_done
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  logic          s_acc, m_acc;
  logic [1:0]    res_count;
  result_t       res0, res1;
  result_t       queue [QUEUE_DEPTH];
  logic [QAW-1:0] head, tail;
  logic [QAW:0]  count, count_next;
  logic [QAW:0]  push_n;
  result_t       out_res;

  ptls_parser #(
    .COORD_BITS (COORD_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (s_acc),
    .path_char  (s_tdata),
    .final_char (s_tlast),
    .res_count  (res_count),
    .res0       (res0),
    .res1       (res1)
  );

  assign s_tready = (count <= (QAW+1)'(QUEUE_DEPTH - 2));
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign m_acc    = m_tvalid && m_tready;
  assign push_n   = s_acc ? (QAW+1)'(res_count) : '0;
  assign count_next = count + push_n - (QAW+1)'(m_acc);

  assign out_res  = queue[head];
  assign m_tdata  = {out_res.y_to, out_res.x_to, out_res.y_from, out_res.x_from};
  assign m_tuser  = out_res.status;
  assign m_tlast  = out_res.path_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QAW'(m_acc);
      tail  <= tail + push_n[QAW-1:0];
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && res_count != 2'd0) begin
      queue[tail] <= res0;
    end
    if (s_acc && res_count == 2'd2) begin
      queue[tail + QAW'(1)] <= res1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ptls_checker.sv
// ----------------------------------------------------------------------------
// ptls_checker
// Port-level checks for the path text to line segments core, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptls_checker import ptls_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_SEGMENT |-> m_tdata == '0)
    else $error("status result carries coordinates");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_END |-> m_tlast)
    else $error("path end result without tlast");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind path_text_to_line_segments_core ptls_checker u_ptls_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams path text into path_text_to_line_segments_core byte by byte and
// checks every segment and status result against a behavioural model of the
// parser kept in the bench. Directed paths cover each command, the error
// cases and the extremes; random paths, noise, back-pressure and a sender
// pause follow, with random idling on both sides until the closing part.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ptls_pkg::*;

  localparam int          COORD_BITS  = COORD_BITS_DEF;
  localparam logic [63:0] COORD_TOP   = (64'd1 << COORD_BITS) - 64'd1;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          LONG_HOLD   = 300;
  localparam int          SETTLE      = 8;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  path_text_to_line_segments_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // parser model state
  phase_t      pm_phase;
  cmd_t        pm_kind;
  int          pm_count;
  logic [63:0] pm_accum;
  bit          pm_in_number;
  logic [63:0] pm_held_x;
  logic [63:0] pm_cur_x, pm_cur_y, pm_start_x, pm_start_y;
  bit          pm_failed;

  result_t     byte_results[$];
  result_t     pending_results[$];
  logic [7:0]  path_bytes[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  int mismatches   = 0;
  int bytes_in     = 0;
  int paths_in     = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int status_seen[8];

  function automatic void clear_path();
    pm_phase     = PH_COMMAND;
    pm_kind      = CMD_MOVE;
    pm_count     = 0;
    pm_accum     = '0;
    pm_in_number = 1'b0;
    pm_held_x    = '0;
    pm_cur_x     = '0;
    pm_cur_y     = '0;
    pm_start_x   = '0;
    pm_start_y   = '0;
    pm_failed    = 1'b0;
  endfunction

  function automatic void add_result(logic [63:0] xf, logic [63:0] yf, logic [63:0] xt,
                                     logic [63:0] yt, status_t st);
    result_t r;
    if (byte_results.size() >= 2) return;
    r        = '0;
    r.x_from = xf[15:0];
    r.y_from = yf[15:0];
    r.x_to   = xt[15:0];
    r.y_to   = yt[15:0];
    r.status = st;
    byte_results.push_back(r);
  endfunction

  function automatic void raise_error(status_t st);
    add_result('0, '0, '0, '0, st);
    pm_failed = 1'b1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void close_operand();
    logic [63:0] v;
    int          need;
    v            = pm_accum;
    need         = (pm_kind == CMD_CUBIC) ? int'(OPS_CUBIC) : int'(OPS_PAIR);
    pm_in_number = 1'b0;
    pm_accum     = '0;
    pm_count     = pm_count + 1;
    if (pm_count % 2 == 1) pm_held_x = v;
    if (pm_count >= need) begin
      pm_phase = PH_COMMAND;
      pm_count = 0;
      if (pm_kind == CMD_MOVE) begin
        pm_start_x = pm_held_x;
        pm_start_y = v;
        pm_cur_x   = pm_held_x;
        pm_cur_y   = v;
      end else if (pm_kind == CMD_LINE) begin
        add_result(pm_cur_x, pm_cur_y, pm_held_x, v, ST_SEGMENT);
        pm_cur_x = pm_held_x;
        pm_cur_y = v;
      end else begin
        raise_error(ST_CUBIC);
      end
    end
  endfunction

  function automatic void take_letter(logic [7:0] c);
    if (c == CH_MOVE || c == CH_LINE || c == CH_CUBIC) begin
      pm_kind      = (c == CH_MOVE) ? CMD_MOVE : ((c == CH_LINE) ? CMD_LINE : CMD_CUBIC);
      pm_phase     = PH_OPERAND;
      pm_count     = 0;
      pm_in_number = 1'b0;
      pm_accum     = '0;
    end else if (c == CH_CLOSE) begin
      add_result(pm_cur_x, pm_cur_y, pm_start_x, pm_start_y, ST_SEGMENT);
      pm_cur_x = pm_start_x;
      pm_cur_y = pm_start_y;
    end else begin
      raise_error(ST_UNKNOWN);
    end
  endfunction

  // works out the results of one accepted byte and queues them
  function automatic void trace_path_byte(logic [7:0] c, bit fin);
    logic [63:0] v;
    byte_results.delete();
    if (pm_failed) begin
      if (fin) clear_path();
      return;
    end
    if (pm_in_number) begin
      if (is_numeral(c)) begin
        v        = pm_accum * 64'd10 + 64'(c - CH_ZERO);
        pm_accum = (v > COORD_TOP) ? COORD_TOP : v;
      end else if (c == CH_DOT) begin
        raise_error(ST_DECIMAL);
      end else begin
        close_operand();
        if (!pm_failed && !is_blank(c)) begin
          if (pm_phase == PH_COMMAND) take_letter(c);
          else raise_error(ST_DIGIT);
        end
      end
    end else if (pm_phase == PH_OPERAND) begin
      if (is_numeral(c)) begin
        pm_in_number = 1'b1;
        pm_accum     = 64'(c - CH_ZERO);
      end else if (!is_blank(c)) begin
        raise_error(ST_DIGIT);
      end
    end else if (!is_blank(c)) begin
      take_letter(c);
    end
    if (fin) begin
      if (!pm_failed) begin
        if (pm_in_number) close_operand();
        if (!pm_failed) begin
          if (pm_phase != PH_COMMAND) raise_error(ST_EARLY);
          else if (byte_results.size() == 0) add_result('0, '0, '0, '0, ST_END);
        end
      end
      if (byte_results.size() > 0) byte_results[byte_results.size()-1].path_done = 1'b1;
      clear_path();
    end
    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
  endfunction

  initial clear_path();

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        trace_path_byte(s_tdata, s_tlast);
        bytes_in++;
        if (s_tlast) paths_in++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: data %h status %0d done %0b",
                     m_tdata, m_tuser, m_tlast);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (m_tdata[15:0] !== want.x_from || m_tdata[31:16] !== want.y_from ||
              m_tdata[47:32] !== want.x_to || m_tdata[63:48] !== want.y_to ||
              m_tuser !== want.status || m_tlast !== want.path_done) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected (%0d,%0d)->(%0d,%0d) st %0d done %0b",
                       want.x_from, want.y_from, want.x_to, want.y_to, want.status,
                       want.path_done);
              $display("          got (%0d,%0d)->(%0d,%0d) st %0d done %0b",
                       m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                       m_tdata[63:48], m_tuser, m_tlast);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("path_text_to_line_segments_core test failed");
      $finish;
    end
  end

  // receiver: random stall bursts and one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] c, bit fin);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_bytes();
    foreach (path_bytes[i]) send_byte(path_bytes[i], i == path_bytes.size() - 1);
  endtask

  task automatic send_text(string s);
    path_bytes.delete();
    for (int i = 0; i < s.len(); i++) path_bytes.push_back(s[i]);
    send_bytes();
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic void add_blanks(int lo, int hi);
    int k;
    repeat ($urandom_range(lo, hi)) begin
      k = $urandom_range(0, 5);
      path_bytes.push_back(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
    end
  endfunction

  function automatic void add_number();
    int unsigned v;
    string       s;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(65536, 9999999);
      1, 2:    v = $urandom_range(0, 9);
      3:       v = 65535;
      default: v = $urandom_range(0, 65535);
    endcase
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) path_bytes.push_back(s[i]);
  endfunction

  // mostly well-formed paths, a few with a damaged byte or cut short
  function automatic void compose_path();
    int          sel;
    int          ops;
    int          pos;
    logic [7:0]  letter;
    path_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      add_blanks(0, 1);
      sel    = $urandom_range(0, 19);
      letter = (sel < 6) ? CH_MOVE : (sel < 14) ? CH_LINE : (sel < 18) ? CH_CLOSE : CH_CUBIC;
      path_bytes.push_back(letter);
      if (letter != CH_CLOSE) begin
        ops = (letter == CH_CUBIC) ? int'(OPS_CUBIC) : int'(OPS_PAIR);
        for (int j = 0; j < ops; j++) begin
          add_blanks(j == 0 ? 0 : 1, 2);
          add_number();
        end
      end
    end
    add_blanks(0, 1);
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, path_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0:       while (path_bytes.size() > pos + 1) void'(path_bytes.pop_back());
        1:       path_bytes[pos] = 8'($urandom_range(0, 255));
        default: path_bytes.insert(pos, CH_DOT);
      endcase
    end
  endfunction

  task automatic test_directed();
    send_text("M10 20L65535 0z");
    send_text("L999999 7\t\n\013\014\r");
    send_text("C1 2 3 4 5 6 L1 1");
    send_text("L1.5");
    send_text("L x");
    send_text("L1x");
    send_text("M5");
    send_text("z");
    send_text(" ");
    send_text("L0 0");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_CLOSE, 1'b1);
  endtask

  task automatic test_random_paths(int n_bytes);
    int stop_at;
    stop_at = bytes_in + n_bytes;
    while (bytes_in < stop_at) begin
      compose_path();
      send_bytes();
    end
  endtask

  task automatic test_back_pressure();
    hold_req = 1'b1;
    path_bytes.delete();
    path_bytes.push_back(CH_MOVE);
    path_bytes.push_back(CH_ZERO + 8'd7);
    path_bytes.push_back(CH_SPACE);
    path_bytes.push_back(CH_ZERO + 8'd9);
    repeat (80) path_bytes.push_back(CH_CLOSE);
    send_bytes();
  endtask

  task automatic test_sender_pause();
    wait_drained();
    test_random_paths(100);
  endtask

  task automatic test_noise(int n_bytes);
    repeat (n_bytes) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    send_byte(CH_SPACE, 1'b1);
  endtask

  task automatic test_steady_stream();
    wait_drained();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_paths(200);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_paths(700);
    test_back_pressure();
    test_sender_pause();
    test_noise(220);
    test_steady_stream();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d bytes in %0d paths, %0d results checked, %0d mismatches",
             bytes_in, paths_in, results_seen, mismatches);
    $display("results by kind: seg %0d end %0d unknown %0d digit %0d dot %0d early %0d cubic %0d",
             status_seen[ST_SEGMENT], status_seen[ST_END], status_seen[ST_UNKNOWN],
             status_seen[ST_DIGIT], status_seen[ST_DECIMAL], status_seen[ST_EARLY],
             status_seen[ST_CUBIC]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("path_text_to_line_segments_core test passed");
    end else begin
      $display("path_text_to_line_segments_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/ptls_pkg.sv
rtl/ptls_parser.sv
rtl/path_text_to_line_segments_core.sv
rtl/ptls_checker.sv
bench/tb_top.sv
